@@ src/assert_macros.svh @@
// Assertion macros shared by the checker of the extended register port.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define SXRP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication with a fixed delay in cycles.
`define SXRP_ASSERT_LAT(lbl, ante, n, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

@@ src/sxrp_pkg.sv @@
// Package with constants and types of the extended register port.
`default_nettype none
package sxrp_pkg;

	localparam int EXT_REG_COUNT  = 256;
	localparam int CRTC_REG_COUNT = 64;

	localparam logic [15:0] PORT_EXT_INDEX  = 16'h01CE;
	localparam logic [15:0] PORT_EXT_DATA   = 16'h01CF;
	localparam logic [15:0] PORT_CRTC_INDEX = 16'h03D4;
	localparam logic [15:0] PORT_CRTC_DATA  = 16'h03D5;
	localparam logic [15:0] PORT_MONO_PAGE  = 16'h03B0;
	localparam logic [15:0] PORT_COLOR_PAGE = 16'h03D0;
	localparam logic [15:0] PORT_PAGE_MASK  = 16'hFFF0;
	localparam logic [15:0] MONO_REMAP      = 16'h0060;

	localparam logic [7:0] EXT_MODE      = 8'hB0;
	localparam logic [7:0] EXT_BANK      = 8'hB2;
	localparam logic [7:0] EXT_EEPROM    = 8'hB3;
	localparam logic [7:0] EXT_EEPROM_IN = 8'hB7;
	localparam logic [7:0] EXT_BANK_CFG  = 8'hBE;

	localparam int CRTC_OVERFLOW  = 'h07;
	localparam int CRTC_PROTECT   = 'h11;
	localparam int CRTC_QUIET_LO  = 'h0E;
	localparam int CRTC_QUIET_HI  = 'h10;

	typedef struct packed {
		logic       idx_we;
		logic       data_we;
		logic [7:0] wdata;
	} reg_cmd_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic [7:0] index;
		logic       is_eeprom;
		logic       is_eeprom_in;
		logic [2:0] rd_bank;
		logic [2:0] wr_bank;
		logic       mode_256;
	} ext_stat_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic [7:0] index;
		logic       dropped;
		logic       recalc;
	} crtc_stat_t;

endpackage
`default_nettype wire

@@ src/sxrp_ext_file.sv @@
// Extended register file: index register, register memory and bank shadows.
`default_nettype none
module sxrp_ext_file #(
	parameter int EXT_REG_COUNT = sxrp_pkg::EXT_REG_COUNT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  sxrp_pkg::reg_cmd_t       cmd,
	output sxrp_pkg::ext_stat_t      stat
);

	localparam int AW = $clog2(EXT_REG_COUNT);

	logic [AW-1:0]            index_q;
	logic [AW-1:0]            index_d;
	logic [7:0]               mem [EXT_REG_COUNT];
	logic [EXT_REG_COUNT-1:0] valid_q;
	logic [7:0]               mem_rd_q;
	logic                     rd_valid_q;
	logic                     byp_q;
	logic [7:0]               byp_data_q;
	logic                     mode_q;
	logic                     mode_d;
	logic [7:0]               bank_q;
	logic [7:0]               bank_d;
	logic                     split_q;
	logic                     split_d;

	// The next item reads at the index this item leaves behind.
	assign index_d = cmd.idx_we ? cmd.wdata[AW-1:0] : index_q;

	always_comb begin
		mode_d  = mode_q;
		bank_d  = bank_q;
		split_d = split_q;
		if (cmd.data_we) begin
			if (index_q == AW'(sxrp_pkg::EXT_MODE)) begin
				mode_d = cmd.wdata[5];
			end
			if (index_q == AW'(sxrp_pkg::EXT_BANK)) begin
				bank_d = cmd.wdata;
			end
			if (index_q == AW'(sxrp_pkg::EXT_BANK_CFG)) begin
				split_d = cmd.wdata[3];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.data_we) begin
			mem[index_q] <= cmd.wdata;
		end
		mem_rd_q   <= mem[index_d];
		byp_data_q <= cmd.wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q    <= '0;
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			byp_q      <= 1'b0;
			mode_q     <= 1'b0;
			bank_q     <= '0;
			split_q    <= 1'b0;
		end else begin
			index_q    <= index_d;
			rd_valid_q <= valid_q[index_d];
			byp_q      <= cmd.data_we && (index_q == index_d);
			if (cmd.data_we) begin
				valid_q[index_q] <= 1'b1;
			end
			mode_q  <= mode_d;
			bank_q  <= bank_d;
			split_q <= split_d;
		end
	end

	always_comb begin
		stat.rdata        = byp_q ? byp_data_q : (rd_valid_q ? mem_rd_q : 8'h00);
		stat.index        = 8'(index_q);
		stat.is_eeprom    = index_q == AW'(sxrp_pkg::EXT_EEPROM);
		stat.is_eeprom_in = index_q == AW'(sxrp_pkg::EXT_EEPROM_IN);
		stat.wr_bank      = bank_d[3:1];
		stat.rd_bank      = split_d ? bank_d[7:5] : bank_d[3:1];
		stat.mode_256     = mode_d;
	end

endmodule
`default_nettype wire

@@ src/sxrp_crtc_file.sv @@
// CRTC register file with index register, write protect and change detect.
`default_nettype none
module sxrp_crtc_file #(
	parameter int CRTC_REG_COUNT = sxrp_pkg::CRTC_REG_COUNT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  sxrp_pkg::reg_cmd_t       cmd,
	output sxrp_pkg::crtc_stat_t     stat
);

	localparam int CAW = $clog2(CRTC_REG_COUNT);

	logic [CAW-1:0]            index_q;
	logic [CAW-1:0]            index_d;
	logic [7:0]                mem [CRTC_REG_COUNT];
	logic [CRTC_REG_COUNT-1:0] valid_q;
	logic [7:0]                mem_rd_q;
	logic                      rd_valid_q;
	logic                      byp_q;
	logic [7:0]                byp_data_q;
	logic                      prot_q;
	logic [7:0]                old_val;
	logic [7:0]                new_val;
	logic                      dropped;
	logic                      store;
	logic                      quiet;

	assign index_d = cmd.idx_we ? cmd.wdata[CAW-1:0] : index_q;
	assign old_val = byp_q ? byp_data_q : (rd_valid_q ? mem_rd_q : 8'h00);

	always_comb begin
		dropped = cmd.data_we && prot_q && (index_q < CAW'(sxrp_pkg::CRTC_OVERFLOW));
		store   = cmd.data_we && !dropped;
		new_val = cmd.wdata;
		// Under protection only bit 4 of the overflow register may change.
		if (prot_q && (index_q == CAW'(sxrp_pkg::CRTC_OVERFLOW))) begin
			new_val = {old_val[7:5], cmd.wdata[4], old_val[3:0]};
		end
		quiet = (index_q >= CAW'(sxrp_pkg::CRTC_QUIET_LO))
			&& (index_q <= CAW'(sxrp_pkg::CRTC_QUIET_HI));
	end

	always_ff @(posedge clk) begin
		if (store) begin
			mem[index_q] <= new_val;
		end
		mem_rd_q   <= mem[index_d];
		byp_data_q <= new_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q    <= '0;
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			byp_q      <= 1'b0;
			prot_q     <= 1'b0;
		end else begin
			index_q    <= index_d;
			rd_valid_q <= valid_q[index_d];
			byp_q      <= store && (index_q == index_d);
			if (store) begin
				valid_q[index_q] <= 1'b1;
				if (index_q == CAW'(sxrp_pkg::CRTC_PROTECT)) begin
					prot_q <= new_val[7];
				end
			end
		end
	end

	always_comb begin
		stat.rdata   = old_val;
		stat.index   = 8'(index_q);
		stat.dropped = dropped;
		stat.recalc  = store && (old_val != new_val) && !quiet;
	end

endmodule
`default_nettype wire

@@ src/svga_extended_register_port.sv @@
// Top level of the extended register port: input stages, decode and result register.
`default_nettype none
// One I/O bus access is a transfer on the command channel: it is taken at a rising
// edge where start is high and busy is low. busy is always low, so one access
// can be taken in every cycle.
// Each access gives exactly one result, shown for one cycle with done high. The access
// is registered in the input stage, then moved to the decode stage, where the extended
// and CRTC register memories are read at the indexes that the access ahead of it
// leaves, and then the result register takes the result and raises done.
// Throughput is one access per cycle, set by the single memory read port of each
// register file, with forwarding of the index and data that the access in decode
// writes.
// The receiver cannot hold results off; a result not taken in its cycle is lost.
// Reset clears both index registers and marks every register of both files as
// zero through per-entry valid bits, so no clearing pass is needed and the block
// accepts accesses as soon as reset is released.
// rd_bank, wr_bank and extended_256_colour give the state after the access.
module svga_extended_register_port #(
	parameter int EXT_REG_COUNT  = sxrp_pkg::EXT_REG_COUNT,
	parameter int CRTC_REG_COUNT = sxrp_pkg::CRTC_REG_COUNT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        action,
	input  wire logic [15:0] port_addr,
	input  wire logic [7:0]  write_data,
	input  wire logic        eeprom_bit,
	input  wire logic        color_io_mode,
	output logic             done,
	output logic [7:0]       read_data,
	output logic             forward_valid,
	output logic [15:0]      forward_addr,
	output logic [2:0]       rd_bank,
	output logic [2:0]       wr_bank,
	output logic             eeprom_strobe,
	output logic             eeprom_select,
	output logic             eeprom_clock,
	output logic             eeprom_din,
	output logic             timing_recalc,
	output logic             extended_256_colour
);

	logic        v_s1;
	logic        action_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;
	logic        ee_s1;
	logic        colour_s1;
	logic        v_s2;
	logic        action_s2;
	logic [15:0] addr_s2;
	logic [7:0]  data_s2;
	logic        ee_s2;
	logic        colour_s2;

	logic [15:0] page;
	logic [15:0] addr_m;
	logic        hit_ei;
	logic        hit_ed;
	logic        hit_ci;
	logic        hit_cd;
	logic        wr;
	logic [7:0]  rd;
	logic [7:0]  ext_rd;
	logic        fwd;
	logic        strobe;

	sxrp_pkg::reg_cmd_t   ext_cmd;
	sxrp_pkg::reg_cmd_t   crtc_cmd;
	sxrp_pkg::ext_stat_t  ext_stat;
	sxrp_pkg::crtc_stat_t crtc_stat;

	logic        done_q;
	logic [7:0]  read_data_q;
	logic        forward_valid_q;
	logic [15:0] forward_addr_q;
	logic [2:0]  rd_bank_q;
	logic [2:0]  wr_bank_q;
	logic        eeprom_strobe_q;
	logic        eeprom_select_q;
	logic        eeprom_clock_q;
	logic        eeprom_din_q;
	logic        timing_recalc_q;
	logic        ext_256_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start && !busy;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		action_s1 <= action;
		addr_s1   <= port_addr;
		data_s1   <= write_data;
		ee_s1     <= eeprom_bit;
		colour_s1 <= color_io_mode;
		action_s2 <= action_s1;
		addr_s2   <= addr_s1;
		data_s2   <= data_s1;
		ee_s2     <= ee_s1;
		colour_s2 <= colour_s1;
	end

	always_comb begin
		page   = addr_s2 & sxrp_pkg::PORT_PAGE_MASK;
		addr_m = addr_s2;
		if (((page == sxrp_pkg::PORT_MONO_PAGE) || (page == sxrp_pkg::PORT_COLOR_PAGE))
			&& !colour_s2) begin
			addr_m = addr_s2 ^ sxrp_pkg::MONO_REMAP;
		end
		hit_ei = addr_m == sxrp_pkg::PORT_EXT_INDEX;
		hit_ed = addr_m == sxrp_pkg::PORT_EXT_DATA;
		hit_ci = addr_m == sxrp_pkg::PORT_CRTC_INDEX;
		hit_cd = addr_m == sxrp_pkg::PORT_CRTC_DATA;
		wr     = v_s2 && action_s2;

		ext_cmd.idx_we   = wr && hit_ei;
		ext_cmd.data_we  = wr && hit_ed;
		ext_cmd.wdata    = data_s2;
		crtc_cmd.idx_we  = wr && hit_ci;
		crtc_cmd.data_we = wr && hit_cd;
		crtc_cmd.wdata   = data_s2;
	end

	sxrp_ext_file #(
		.EXT_REG_COUNT(EXT_REG_COUNT)
	) u_ext (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ext_cmd),
		.stat   (ext_stat)
	);

	sxrp_crtc_file #(
		.CRTC_REG_COUNT(CRTC_REG_COUNT)
	) u_crtc (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (crtc_cmd),
		.stat   (crtc_stat)
	);

	always_comb begin
		ext_rd = ext_stat.rdata;
		// The EEPROM data output shows through as bit 3 of its input register.
		if (ext_stat.is_eeprom_in) begin
			ext_rd[3] = ee_s2;
		end
		rd  = 8'h00;
		fwd = 1'b1;
		if (action_s2) begin
			if (hit_ci) begin
				fwd = 1'b0;
			end else if (hit_cd && crtc_stat.dropped) begin
				fwd = 1'b0;
			end
		end else begin
			if (hit_ei) begin
				rd  = ext_stat.index;
				fwd = 1'b0;
			end else if (hit_ed) begin
				rd  = ext_rd;
				fwd = 1'b0;
			end else if (hit_ci) begin
				rd  = crtc_stat.index;
				fwd = 1'b0;
			end else if (hit_cd) begin
				rd  = crtc_stat.rdata;
				fwd = 1'b0;
			end
		end
		strobe = ext_cmd.data_we && ext_stat.is_eeprom;
	end

	always_ff @(posedge clk) begin
		read_data_q     <= rd;
		forward_valid_q <= fwd;
		forward_addr_q  <= addr_m;
		rd_bank_q       <= ext_stat.rd_bank;
		wr_bank_q       <= ext_stat.wr_bank;
		eeprom_strobe_q <= strobe;
		eeprom_select_q <= strobe && data_s2[3];
		eeprom_clock_q  <= strobe && data_s2[1];
		eeprom_din_q    <= strobe && data_s2[0];
		timing_recalc_q <= crtc_stat.recalc;
		ext_256_q       <= ext_stat.mode_256;
	end

	assign done                = done_q;
	assign read_data           = read_data_q;
	assign forward_valid       = forward_valid_q;
	assign forward_addr        = forward_addr_q;
	assign rd_bank             = rd_bank_q;
	assign wr_bank             = wr_bank_q;
	assign eeprom_strobe       = eeprom_strobe_q;
	assign eeprom_select       = eeprom_select_q;
	assign eeprom_clock        = eeprom_clock_q;
	assign eeprom_din          = eeprom_din_q;
	assign timing_recalc       = timing_recalc_q;
	assign extended_256_colour = ext_256_q;

endmodule
`default_nettype wire

@@ src/sxrp_checker.sv @@
// Port-level checker of the extended register port and its bind statement.
`default_nettype none
`include "assert_macros.svh"
module sxrp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic [7:0] read_data,
	input wire logic       forward_valid,
	input wire logic       eeprom_strobe,
	input wire logic       timing_recalc
);

	`SXRP_ASSERT_LAT(a_result_latency, start && !busy, 3, done, "Transfer gave no result after three cycles.")
	`SXRP_ASSERT_LAT(a_no_spurious, !(start && !busy), 3, !done, "Result appeared without a transfer.")
	`SXRP_ASSERT_IMP(a_strobe_in_result, eeprom_strobe, done, "EEPROM strobe outside a result.")
	`SXRP_ASSERT_IMP(a_recalc_forwarded, timing_recalc, done && forward_valid, "Timing recalculation on a dropped or absent write.")
	`SXRP_ASSERT_IMP(a_read_handled, done && (read_data != 8'h00), !forward_valid, "Handled read data on a forwarded access.")

endmodule

bind svga_extended_register_port sxrp_checker u_sxrp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.read_data     (read_data),
	.forward_valid (forward_valid),
	.eeprom_strobe (eeprom_strobe),
	.timing_recalc (timing_recalc)
);
`default_nettype wire
